### rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg : shared types and constants of the hash table
// field widths, action codes and the structs passed between front and back
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int KEY_W  = 32;
    localparam int ITEM_W = 32;
    localparam int CNT_W  = 9;
    localparam int ACT_W  = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] ENTRY_LIMIT_RST = 9'd128;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [KEY_W-1:0]  key;
        logic [ITEM_W-1:0] item;
    } cmd_t;

    typedef struct packed {
        logic              hit;
        logic [ITEM_W-1:0] item_out;
        logic              inserted;
        logic              full_res;
        logic [CNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

### rtl/lph_req_if.sv
// ----------------------------------------------------------------------------
// lph_req_if : request channel
// valid/ready channel carrying one operation word
// ----------------------------------------------------------------------------
interface lph_req_if;
    import lph_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;

    modport source (output valid, action, key, item, input ready);
    modport sink   (input valid, action, key, item, output ready);

endinterface

### rtl/lph_rsp_if.sv
// ----------------------------------------------------------------------------
// lph_rsp_if : response channel
// valid/ready channel carrying one result word
// ----------------------------------------------------------------------------
interface lph_rsp_if;
    import lph_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [ITEM_W-1:0] item_out;
    logic              inserted;
    logic              full_res;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, hit, item_out, inserted, full_res, entry_count,
                    input ready);
    modport sink   (input valid, hit, item_out, inserted, full_res, entry_count,
                    output ready);

endinterface

### rtl/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram : generic single write, single read ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module lph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/lph_front.sv
// ----------------------------------------------------------------------------
// lph_front : request intake
// takes a request word and works out its home slot, key mod SLOTS
// ----------------------------------------------------------------------------
module lph_front #(
    parameter int SLOTS = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    lph_req_if.sink                  req,
    input  logic                     q_full,
    output logic                     push,
    output logic [$clog2(SLOTS)-1:0] home,
    output lph_pkg::cmd_t            cmd
);
    import lph_pkg::*;

    localparam int  IDX_W  = $clog2(SLOTS);
    localparam int  REM_W  = IDX_W + 1;
    localparam bit  POW2   = (SLOTS & (SLOTS - 1)) == 0;
    localparam int  DIGIT  = 4;
    localparam int  STEPS  = KEY_W / DIGIT;
    localparam int  STEP_W = $clog2(STEPS + 1);

    logic              have_reg;
    cmd_t              cmd_reg;
    logic [KEY_W-1:0]  sh_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;

    logic [IDX_W-1:0]  rem_next;
    logic              done;
    logic              accept;

    // four bits of remainder reduction per cycle, msb first
    always_comb
    begin
        logic [IDX_W-1:0] r;
        logic [REM_W-1:0] t;
        r = rem_reg;
        for (int i = 0; i < DIGIT; i++)
        begin
            t = {r, sh_reg[KEY_W-1-i]};
            if (t >= REM_W'(SLOTS))
            begin
                t = t - REM_W'(SLOTS);
            end
            r = t[IDX_W-1:0];
        end
        rem_next = r;
    end

    assign done      = have_reg && (POW2 || (step_reg == STEP_W'(STEPS)));
    assign push      = done && !q_full;
    assign req.ready = !have_reg || push;
    assign accept    = req.valid && req.ready;
    assign home      = POW2 ? cmd_reg.key[IDX_W-1:0] : rem_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            cmd_reg  <= '0;
            sh_reg   <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (accept)
        begin
            have_reg       <= 1'b1;
            cmd_reg.action <= req.action;
            cmd_reg.key    <= req.key;
            cmd_reg.item   <= req.item;
            sh_reg         <= req.key;
            rem_reg        <= '0;
            step_reg       <= '0;
        end
        else if (push)
        begin
            have_reg <= 1'b0;
        end
        else if (have_reg && !done)
        begin
            rem_reg  <= rem_next;
            sh_reg   <= sh_reg << DIGIT;
            step_reg <= step_reg + 1'b1;
        end
    end

endmodule

### rtl/lph_queue.sv
// ----------------------------------------------------------------------------
// lph_queue : short fifo between front and back
// lets front and back stall independently
// ----------------------------------------------------------------------------
module lph_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    assign full      = fill_reg == FILL_W'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/lph_back.sv
// ----------------------------------------------------------------------------
// lph_back : probe engine
// walks the probe sequence in the slot rams, updates them, clears them,
// and holds the result word
// ----------------------------------------------------------------------------
module lph_back #(
    parameter int SLOTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lph_pkg::CNT_W-1:0]     entry_limit,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [$clog2(SLOTS)-1:0]      q_home,
    input  lph_pkg::cmd_t                 q_cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lph_pkg::rsp_t                 out_rsp
);
    import lph_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_PROBE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] n_reg;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] sweep_reg;
    logic             sweep_rsp_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;

    // slot ram signals, valid bit on top of the key
    logic                key_we;
    logic [IDX_W-1:0]    key_waddr;
    logic [KEY_W:0]      key_wdata;
    logic [KEY_W:0]      key_rd;
    logic                item_we;
    logic [ITEM_W-1:0]   item_rd;
    logic [IDX_W-1:0]    rd_addr;

    logic             out_free;
    logic             start;
    logic [IDX_W-1:0] idx_wrap;
    logic             probe_hit;
    logic             probe_empty;
    logic             probe_done;
    logic             is_put;
    logic             can_insert;
    logic             do_insert;

    // result word loaded this cycle
    logic             rsp_load;
    rsp_t             rsp_next;

    assign out_free    = !out_valid_reg || out_ready;
    assign start       = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_pop       = start;
    assign idx_wrap    = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
    assign probe_empty = !key_rd[KEY_W];
    assign probe_hit   = key_rd[KEY_W] && (key_rd[KEY_W-1:0] == cmd_reg.key);
    assign probe_done  = (state_reg == S_PROBE) &&
                         (probe_hit || probe_empty || (n_reg == LAST));
    assign is_put      = cmd_reg.action == ACT_PUT;
    assign can_insert  = probe_empty && (count_reg < entry_limit);
    assign do_insert   = probe_done && is_put && !probe_hit && can_insert;

    // next slot is fetched while the current one is checked
    assign rd_addr   = (state_reg == S_PROBE) ? idx_wrap : q_home;
    assign key_we    = (state_reg == S_SWEEP) || do_insert;
    assign key_waddr = (state_reg == S_SWEEP) ? sweep_reg : idx_reg;
    assign key_wdata = (state_reg == S_SWEEP) ? '0 : {1'b1, cmd_reg.key};
    assign item_we   = probe_done && is_put && (probe_hit || can_insert);

    lph_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    lph_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (SLOTS)
    ) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (idx_reg),
        .wdata (cmd_reg.item),
        .raddr (rd_addr),
        .rdata (item_rd)
    );

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    // result word for the operation finishing this cycle
    always_comb
    begin
        rsp_load = 1'b0;
        rsp_next = '0;
        case (state_reg)
            S_SWEEP:
            begin
                if ((sweep_reg == LAST) && sweep_rsp_reg)
                begin
                    rsp_load = 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    case (q_cmd.action)
                        ACT_PUT, ACT_GET, ACT_CLEAR:
                        begin
                        end
                        default:
                        begin
                            rsp_load             = 1'b1;
                            rsp_next.entry_count = count_reg;
                        end
                    endcase
                end
            end

            S_PROBE:
            begin
                if (probe_done)
                begin
                    rsp_load     = 1'b1;
                    rsp_next.hit = probe_hit;
                    if (is_put)
                    begin
                        rsp_next.inserted    = !probe_hit && can_insert;
                        rsp_next.full_res    = !probe_hit && !can_insert;
                        rsp_next.entry_count = do_insert ? count_reg + 1'b1 : count_reg;
                    end
                    else
                    begin
                        rsp_next.item_out    = probe_hit ? item_rd : '0;
                        rsp_next.entry_count = count_reg;
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            idx_reg       <= '0;
            n_reg         <= '0;
            cmd_reg       <= '0;
            count_reg     <= '0;
            sweep_reg     <= '0;
            sweep_rsp_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= rsp_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= (sweep_reg == LAST) ? '0 : sweep_reg + 1'b1;
                    if (sweep_reg == LAST)
                    begin
                        state_reg     <= S_IDLE;
                        sweep_rsp_reg <= 1'b0;
                    end
                end

                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= q_cmd;
                        idx_reg <= q_home;
                        n_reg   <= '0;
                        case (q_cmd.action)
                            ACT_PUT, ACT_GET:
                            begin
                                state_reg <= S_PROBE;
                            end
                            ACT_CLEAR:
                            begin
                                count_reg     <= '0;
                                sweep_reg     <= '0;
                                sweep_rsp_reg <= 1'b1;
                                state_reg     <= S_SWEEP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_PROBE:
                begin
                    if (probe_done)
                    begin
                        state_reg <= S_IDLE;
                        if (do_insert)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_wrap;
                        n_reg   <= n_reg + 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table : open addressing hash table, linear probing
// put, get and clear on 32-bit keys and items with a configurable entry limit
// ----------------------------------------------------------------------------
// A put or get starts at the home slot (key mod SLOTS) and reads one slot per
// cycle from the slot memory until it finds the key, an empty slot, or has
// gone round the whole table, so an operation holds the probe engine for its
// start and then one read per slot probed (1 to SLOTS slots); the single
// read port of the slot memory sets that pace. A clear sweeps every slot,
// one slot written per cycle. After reset the engine clears the slot memory
// before it starts the first operation; request words are still taken into
// the queue meanwhile. The intake takes a request word per cycle while the
// queue has room when SLOTS is a power of two (home slot from the low key
// bits), otherwise it reduces the key four bits at a time before passing it
// on. A two-deep queue separates intake and probe engine, and the result
// word waits in an output register, so intake goes on while a result is
// held. The entry limit may be written only while the block is idle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int SLOTS = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lph_pkg::CNT_W-1:0] cfg_wdata,
    lph_req_if.sink                   req,
    lph_rsp_if.source                 rsp
);
    import lph_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMD_W = $bits(cmd_t);
    localparam int Q_W   = IDX_W + CMD_W;

    // entry limit register
    logic [CNT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ENTRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // intake: request word plus its home slot
    logic             f_push;
    logic [IDX_W-1:0] f_home;
    cmd_t             f_cmd;

    // queue side
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [Q_W-1:0]   q_data;
    logic [IDX_W-1:0] q_home;
    cmd_t             q_cmd;

    // result word
    logic             b_valid;
    rsp_t             b_rsp;

    lph_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .push   (f_push),
        .home   (f_home),
        .cmd    (f_cmd)
    );

    lph_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_home, f_cmd}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    // split the queued word back into home slot and operation
    assign q_home = q_data[Q_W-1 -: IDX_W];
    assign q_cmd  = cmd_t'(q_data[CMD_W-1:0]);

    lph_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_limit (limit_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_home      (q_home),
        .q_cmd       (q_cmd),
        .out_valid   (b_valid),
        .out_ready   (rsp.ready),
        .out_rsp     (b_rsp)
    );

    // result channel straight from the output register
    assign rsp.valid       = b_valid;
    assign rsp.hit         = b_rsp.hit;
    assign rsp.item_out    = b_rsp.item_out;
    assign rsp.inserted    = b_rsp.inserted;
    assign rsp.full_res    = b_rsp.full_res;
    assign rsp.entry_count = b_rsp.entry_count;

endmodule

### rtl/lph_checker.sv
// ----------------------------------------------------------------------------
// lph_assertions : port level checks of the hash table
// watches the result channel, bound to the top level
// ----------------------------------------------------------------------------
module lph_assertions (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_hit,
    input logic [lph_pkg::ITEM_W-1:0] rsp_item_out,
    input logic                       rsp_inserted,
    input logic                       rsp_full_res,
    input logic [lph_pkg::CNT_W-1:0]  rsp_entry_count
);

    // a held result word keeps its value
    a_rsp_hold : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
        $stable(rsp_item_out) && $stable(rsp_inserted) &&
        $stable(rsp_full_res) && $stable(rsp_entry_count))
        else $error("result word changed while stalled");

    // update, insert and reject exclude each other
    a_outcome : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0({rsp_hit, rsp_inserted, rsp_full_res}))
        else $error("more than one outcome flag set");

    // item only on a hit
    a_item_zero : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_item_out == '0)
        else $error("item returned without a hit");

    // an insert leaves at least one entry
    a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_inserted |-> rsp_entry_count != '0)
        else $error("insert reported with no entries");

endmodule

bind linear_probe_hash_table lph_assertions u_lph_assertions (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_item_out    (rsp.item_out),
    .rsp_inserted    (rsp.inserted),
    .rsp_full_res    (rsp.full_res),
    .rsp_entry_count (rsp.entry_count)
);
